>>> sv/cubic_bezier_segment_tessellator_macros.svh
// assertion macros for the cubic bezier segment tessellator
// each one samples on clk_i and is disabled while rst_ni is low
`ifndef CUBIC_BEZIER_SEGMENT_TESSELLATOR_MACROS_SVH
`define CUBIC_BEZIER_SEGMENT_TESSELLATOR_MACROS_SVH

// condition holds in the same cycle
`define CBST_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("cbst check failed");

// condition holds in the following cycle
`define CBST_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("cbst check failed");

`endif

>>> sv/cbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbst_pkg
// Types and constants for the cubic bezier segment tessellator.
// ----------------------------------------------------------------------------
package cbst_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;
  localparam int PIX_BITS   = 12;
  localparam int STEPS_BITS = 7;
  localparam int U_BITS     = 17;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PIX_BITS-1:0]   pix_t;
  typedef logic [STEPS_BITS-1:0] steps_t;
  typedef logic [U_BITS-1:0]     u_t;

  localparam steps_t MAX_STEPS   = 7'd64;
  localparam steps_t STEPS_MIN   = 7'd1;
  localparam steps_t STEPS_RESET = 7'd5;
  localparam u_t     U_ONE       = 17'h10000;

  // restoring division of 1.0 by the step count, one quotient bit a cycle
  localparam logic [4:0] DIV_CNT_LAST = 5'd16;

  // micro-op program for one axis: bit set means interpolate, clear means rotate
  localparam logic [3:0]  OP_LAST    = 4'd8;
  localparam logic [15:0] OP_COMPUTE = 16'b0000_0001_0011_0111;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_ROT,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

>>> sv/cubic_bezier_segment_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_segment_tessellator
// Splits a cubic bezier curve into line segments by de Casteljau evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat carries the four control points (Q12.4 pixels).
//   Output channel: one beat per segment, start and end as whole pixels,
//   last_segment set on the final beat of a curve.
//   cfg_we_i writes the step count (segments per curve); 0 acts as 1 and
//   values above 64 act as 64. Write it only while the block is idle.
//   Sequence: a curve of n segments starts by dividing 1.0 by n; then each
//   point runs twelve interpolations through one shared 17x18 multiplier,
//   each a registered multiply step then an add step, plus rotates of the
//   four-entry working register. in_stall_o is high from the accepted beat
//   until the last segment enters the output register.
//   Output stall: the output register holds one beat; while it is stalled
//   the sequencer waits with the next point finished.
//   Reset: step count returns to 5, the sequencer goes idle, no output valid.
// ----------------------------------------------------------------------------
`include "cubic_bezier_segment_tessellator_macros.svh"

module cubic_bezier_segment_tessellator (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  cbst_pkg::steps_t   cfg_wdata_i,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  cbst_pkg::coord_t   p0_x_i,
  input  wire  cbst_pkg::coord_t   p0_y_i,
  input  wire  cbst_pkg::coord_t   p1_x_i,
  input  wire  cbst_pkg::coord_t   p1_y_i,
  input  wire  cbst_pkg::coord_t   p2_x_i,
  input  wire  cbst_pkg::coord_t   p2_y_i,
  input  wire  cbst_pkg::coord_t   p3_x_i,
  input  wire  cbst_pkg::coord_t   p3_y_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output cbst_pkg::pix_t           seg_x_start_o,
  output cbst_pkg::pix_t           seg_y_start_o,
  output cbst_pkg::pix_t           seg_x_end_o,
  output cbst_pkg::pix_t           seg_y_end_o,
  output logic                     last_segment_o
);

  localparam int FB = cbst_pkg::FRAC_BITS;
  localparam int PB = cbst_pkg::PIX_BITS;

  // control state
  cbst_pkg::state_e state_q, state_d;
  cbst_pkg::steps_t steps_q;
  cbst_pkg::steps_t n_q;
  cbst_pkg::steps_t k_q;
  logic [4:0]       div_cnt_q;
  logic [3:0]       op_q;
  logic             axis_q;
  logic             out_valid_q;

  // datapath
  cbst_pkg::coord_t cp_q [8];
  cbst_pkg::coord_t w_q  [4];
  cbst_pkg::u_t     q0_q;
  cbst_pkg::steps_t r0_q;
  cbst_pkg::u_t     u_q;
  cbst_pkg::steps_t racc_q;
  logic signed [34:0] prod_q;
  cbst_pkg::pix_t   prev_x_q, prev_y_q, pix_x_q, pix_y_q;
  cbst_pkg::pix_t   seg_xs_q, seg_ys_q, seg_xe_q, seg_ye_q;
  logic             seg_last_q;

  // sequencer outputs
  logic accept_in, div_done, emit_go, op_is_last, next_compute, last_pt;

  cbst_pkg::steps_t n_clamped;
  logic [7:0]       div_tmp;
  logic             div_ge;
  cbst_pkg::steps_t r0_d;
  cbst_pkg::u_t     q0_d;
  logic [7:0]       rsum;
  logic             rcarry;
  cbst_pkg::steps_t racc_nxt;
  cbst_pkg::u_t     u_nxt;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [18:0] lerp_sum;
  cbst_pkg::coord_t lerp_res;
  logic [3:0]       op_nxt;
  logic [23:0]      div_check;

  // step count clamped to the supported range
  always_comb begin
    if (steps_q == '0) begin
      n_clamped = cbst_pkg::STEPS_MIN;
    end else if (steps_q > cbst_pkg::MAX_STEPS) begin
      n_clamped = cbst_pkg::MAX_STEPS;
    end else begin
      n_clamped = steps_q;
    end
  end

  // restoring divider: dividend is 1.0, a single one at the top bit
  assign div_tmp = {r0_q, (div_cnt_q == '0)};
  assign div_ge  = div_tmp >= {1'b0, n_q};
  assign r0_d    = div_ge ? 7'(div_tmp - {1'b0, n_q}) : div_tmp[6:0];
  assign q0_d    = {q0_q[cbst_pkg::U_BITS-2:0], div_ge};

  // u advance: u += q0, remainder carries one more when it reaches n
  assign rsum     = {1'b0, racc_q} + {1'b0, r0_q};
  assign rcarry   = rsum >= {1'b0, n_q};
  assign racc_nxt = rcarry ? 7'(rsum - {1'b0, n_q}) : rsum[6:0];
  assign u_nxt    = u_q + q0_q + cbst_pkg::u_t'(rcarry);

  // shared interpolator: a + floor((b - a) * u / 1.0)
  assign diff     = $signed({1'b0, w_q[1]}) - $signed({1'b0, w_q[0]});
  assign prod     = diff * $signed({1'b0, u_q});
  assign lerp_sum = $signed({3'b000, w_q[0]}) + $signed(prod_q[34:16]);
  assign lerp_res = lerp_sum[15:0];

  assign op_nxt       = op_q + 4'd1;
  assign op_is_last   = op_q == cbst_pkg::OP_LAST;
  assign next_compute = cbst_pkg::OP_COMPUTE[op_nxt];
  assign last_pt      = k_q == n_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbst_pkg::ST_IDLE: begin
        if (accept_in) state_d = cbst_pkg::ST_DIV;
      end
      cbst_pkg::ST_DIV: begin
        if (div_done) state_d = cbst_pkg::ST_LOAD;
      end
      cbst_pkg::ST_LOAD: begin
        state_d = cbst_pkg::ST_MUL;
      end
      cbst_pkg::ST_MUL: begin
        state_d = cbst_pkg::ST_ADD;
      end
      cbst_pkg::ST_ADD: begin
        if (op_is_last) begin
          state_d = axis_q ? cbst_pkg::ST_EMIT : cbst_pkg::ST_LOAD;
        end else begin
          state_d = next_compute ? cbst_pkg::ST_MUL : cbst_pkg::ST_ROT;
        end
      end
      cbst_pkg::ST_ROT: begin
        state_d = next_compute ? cbst_pkg::ST_MUL : cbst_pkg::ST_ROT;
      end
      cbst_pkg::ST_EMIT: begin
        if (emit_go) state_d = last_pt ? cbst_pkg::ST_IDLE : cbst_pkg::ST_LOAD;
      end
      default: begin
        state_d = cbst_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = state_q != cbst_pkg::ST_IDLE;
    accept_in  = in_valid_i && (state_q == cbst_pkg::ST_IDLE);
    div_done   = (state_q == cbst_pkg::ST_DIV) && (div_cnt_q == cbst_pkg::DIV_CNT_LAST);
    emit_go    = (state_q == cbst_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbst_pkg::ST_IDLE;
      steps_q     <= cbst_pkg::STEPS_RESET;
      n_q         <= cbst_pkg::STEPS_MIN;
      k_q         <= cbst_pkg::STEPS_MIN;
      div_cnt_q   <= '0;
      op_q        <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) steps_q <= cfg_wdata_i;
      if (accept_in) begin
        n_q       <= n_clamped;
        k_q       <= cbst_pkg::STEPS_MIN;
        div_cnt_q <= '0;
        axis_q    <= 1'b0;
      end
      if (state_q == cbst_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 5'd1;
      if (state_q == cbst_pkg::ST_LOAD) op_q <= '0;
      if (state_q == cbst_pkg::ST_ROT) op_q <= op_nxt;
      if (state_q == cbst_pkg::ST_ADD) begin
        if (op_is_last) begin
          axis_q <= ~axis_q;
        end else begin
          op_q <= op_nxt;
        end
      end
      if (emit_go && !last_pt) k_q <= k_q + 7'd1;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cp_q[0]  <= p0_x_i;
      cp_q[1]  <= p0_y_i;
      cp_q[2]  <= p1_x_i;
      cp_q[3]  <= p1_y_i;
      cp_q[4]  <= p2_x_i;
      cp_q[5]  <= p2_y_i;
      cp_q[6]  <= p3_x_i;
      cp_q[7]  <= p3_y_i;
      // point at u = 0 is the first control point itself
      prev_x_q <= p0_x_i[FB+PB-1:FB];
      prev_y_q <= p0_y_i[FB+PB-1:FB];
      q0_q     <= '0;
      r0_q     <= '0;
    end
    if (state_q == cbst_pkg::ST_DIV) begin
      q0_q <= q0_d;
      r0_q <= r0_d;
      if (div_done) begin
        u_q    <= q0_d;
        racc_q <= r0_d;
      end
    end
    if (state_q == cbst_pkg::ST_LOAD) begin
      w_q[0] <= axis_q ? cp_q[1] : cp_q[0];
      w_q[1] <= axis_q ? cp_q[3] : cp_q[2];
      w_q[2] <= axis_q ? cp_q[5] : cp_q[4];
      w_q[3] <= axis_q ? cp_q[7] : cp_q[6];
    end
    if (state_q == cbst_pkg::ST_MUL) prod_q <= prod;
    // interpolate drops the first entry and appends the result; rotate recycles
    if (state_q == cbst_pkg::ST_ADD || state_q == cbst_pkg::ST_ROT) begin
      w_q[0] <= w_q[1];
      w_q[1] <= w_q[2];
      w_q[2] <= w_q[3];
      w_q[3] <= (state_q == cbst_pkg::ST_ADD) ? lerp_res : w_q[0];
    end
    if (state_q == cbst_pkg::ST_ADD && op_is_last) begin
      if (axis_q) begin
        pix_y_q <= lerp_res[FB+PB-1:FB];
      end else begin
        pix_x_q <= lerp_res[FB+PB-1:FB];
      end
    end
    if (emit_go) begin
      seg_xs_q   <= prev_x_q;
      seg_ys_q   <= prev_y_q;
      seg_xe_q   <= pix_x_q;
      seg_ye_q   <= pix_y_q;
      seg_last_q <= last_pt;
      prev_x_q   <= pix_x_q;
      prev_y_q   <= pix_y_q;
      u_q        <= u_nxt;
      racc_q     <= racc_nxt;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign seg_x_start_o  = seg_xs_q;
  assign seg_y_start_o  = seg_ys_q;
  assign seg_x_end_o    = seg_xe_q;
  assign seg_y_end_o    = seg_ye_q;
  assign last_segment_o = seg_last_q;

  assign div_check = ({7'd0, q0_q} * {17'd0, n_q}) + {17'd0, r0_q};

  `CBST_ASSERT_NXT(a_accept_clamps, accept_in, (state_q == cbst_pkg::ST_DIV) && (n_q >= cbst_pkg::STEPS_MIN) && (n_q <= cbst_pkg::MAX_STEPS))
  `CBST_ASSERT_IMP(a_step_in_range, state_q != cbst_pkg::ST_IDLE, (k_q != '0) && (k_q <= n_q))
  `CBST_ASSERT_IMP(a_div_exact, (state_q != cbst_pkg::ST_IDLE) && (state_q != cbst_pkg::ST_DIV), (div_check == 24'(cbst_pkg::U_ONE)) && (racc_q < n_q))
  `CBST_ASSERT_IMP(a_last_at_one, (state_q == cbst_pkg::ST_EMIT) && last_pt, u_q == cbst_pkg::U_ONE)
  `CBST_ASSERT_IMP(a_op_bound, 1'b1, op_q <= cbst_pkg::OP_LAST)

endmodule
`default_nettype wire
